>>> rtl/tq_pkg.sv
// Package for the sorted timeout timer queue: field widths, command and
// result codes, slot states and the command bundle broadcast to the queue cells.
// No dependencies.
package tq_pkg;

    localparam int MODE_W       = 3;
    localparam int SLOT_FIELD_W = 4;
    localparam int TIME_W       = 32;
    localparam int DATA_W       = 8;
    localparam int KIND_W       = 2;

    localparam int DEFAULT_NUM_TIMERS = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 3'd0,
        MODE_ALLOC = 3'd1,
        MODE_FREE  = 3'd2,
        MODE_SET   = 3'd3,
        MODE_ARM   = 3'd4
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_GRANT   = 2'd0,
        KIND_FAIL    = 2'd1,
        KIND_EXPIRED = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_ALLOC = 2'd1,
        ST_ARMED = 2'd2
    } slot_state_t;

    // Command broadcast to every cell of the queue at once.
    typedef struct packed {
        logic              insert;
        logic              pop;
        logic [TIME_W-1:0] key;
        logic [TIME_W-1:0] now;
    } tq_cmd_t;

endpackage

>>> rtl/tq_if.sv
// Handshake interfaces for the request and result channels of the timer queue.
// Depends on tq_pkg for the field widths.
interface tq_req_if
    import tq_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [TIME_W-1:0]       timeout;
    logic [DATA_W-1:0]       data_byte;

    modport source (output valid, output mode, output slot, output timeout,
                    output data_byte, input ready);
    modport sink   (input valid, input mode, input slot, input timeout,
                    input data_byte, output ready);
endinterface

interface tq_rsp_if
    import tq_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       result_kind;
    logic [SLOT_FIELD_W-1:0] slot_index;
    logic [DATA_W-1:0]       fired_data;
    logic                    last;

    modport source (output valid, output result_kind, output slot_index,
                    output fired_data, output last, input ready);
    modport sink   (input valid, input result_kind, input slot_index,
                    input fired_data, input last, output ready);
endinterface

>>> rtl/tq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tq_cell.sv
// One position of the sorted timer queue: holds a slot number and its deadline.
// Depends on tq_pkg for the command bundle and the time width.
module tq_cell
    import tq_pkg::*;
#(
    parameter int SLOT_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tq_cmd_t           cmd,
    input  logic [SLOT_W-1:0] new_slot,
    input  logic              left_valid,
    input  logic              left_shift,
    input  logic [TIME_W-1:0] left_deadline,
    input  logic [SLOT_W-1:0] left_slot,
    input  logic              right_valid,
    input  logic [TIME_W-1:0] right_deadline,
    input  logic [SLOT_W-1:0] right_slot,
    output logic              valid,
    output logic [TIME_W-1:0] deadline,
    output logic [SLOT_W-1:0] slot,
    output logic              shift,
    output logic              due
);

    logic              valid_reg, valid_next;
    logic [TIME_W-1:0] deadline_reg, deadline_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              load_insert;

    // A new entry goes ahead of every entry whose deadline is equal or later.
    assign shift = valid_reg && (deadline_reg >= cmd.key);
    assign due   = valid_reg && (deadline_reg <= cmd.now);

    // This cell changes on insert when its entry moves right, or when it is
    // the first empty position.
    assign load_insert = shift || (!valid_reg && left_valid);

    always_comb
    begin
        valid_next    = valid_reg;
        deadline_next = deadline_reg;
        slot_next     = slot_reg;
        if (cmd.pop)
        begin
            valid_next    = right_valid;
            deadline_next = right_deadline;
            slot_next     = right_slot;
        end
        else if (cmd.insert && load_insert)
        begin
            valid_next = 1'b1;
            if (left_shift)
            begin
                deadline_next = left_deadline;
                slot_next     = left_slot;
            end
            else
            begin
                deadline_next = cmd.key;
                slot_next     = new_slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        slot_reg     <= slot_next;
    end

    assign valid    = valid_reg;
    assign deadline = deadline_reg;
    assign slot     = slot_reg;

endmodule

>>> rtl/sorted_timeout_timer_queue.sv
// Sorted timeout timer queue: pool of timer slots, tick counter and sorted
// deadline queue built from a chain of tq_cell instances.
// Depends on tq_pkg, tq_if (tq_req_if, tq_rsp_if), tq_cell and tq_ram.
//
// The block keeps NUM_TIMERS timer slots and a 32-bit tick counter. Requests
// arrive one item at a time on req; results leave on rsp through an output
// register, so a new request is taken while an earlier result still waits.
// Free, set data and arm complete in the cycle they are accepted and give no
// result. Allocate gives one result (the lowest free slot or a failure). A
// tick with no timer due is accepted and then makes one look at the head cell
// of the queue. Otherwise, for each timer that expires, the sequencer checks
// the head cell of the queue, pops it and reads the slot's data byte from the
// payload RAM through its registered read before it gives the result. Expired
// timers leave in queue order, the final one with last set. The queue itself
// is a row of cells, one per position, each holding a slot number and its
// deadline. Arming compares the new deadline in every cell at once and each
// entry with an equal or later deadline steps one place right; a pop moves
// every entry one place left. Deadlines and the count wrap modulo 2^32 and
// are compared as plain unsigned values. Arm and free on an armed slot are
// ignored, and a slot number not below NUM_TIMERS makes free, set data and
// arm do nothing.
module sorted_timeout_timer_queue
    import tq_pkg::*;
#(
    parameter int NUM_TIMERS = DEFAULT_NUM_TIMERS
) (
    input  logic     clk,
    input  logic     rst_n,
    tq_req_if.sink   req,
    tq_rsp_if.source rsp
);

    localparam int SLOT_W = $clog2(NUM_TIMERS);

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ALLOC = 4'b0010,
        S_CHECK = 4'b0100,
        S_FIRE  = 4'b1000
    } seq_state_t;

    seq_state_t  state_reg, state_next;
    logic [TIME_W-1:0] count_reg, count_next;
    slot_state_t status_reg [NUM_TIMERS];
    slot_state_t status_next [NUM_TIMERS];

    logic [SLOT_W-1:0] fire_slot_reg, fire_slot_next;
    logic              fire_last_reg, fire_last_next;

    logic                    out_valid_reg, out_valid_next;
    kind_t                   out_kind_reg, out_kind_next;
    logic [SLOT_FIELD_W-1:0] out_slot_reg, out_slot_next;
    logic [DATA_W-1:0]       out_data_reg, out_data_next;
    logic                    out_last_reg, out_last_next;

    // Queue cell outputs and neighbour wiring.
    logic              c_valid    [NUM_TIMERS];
    logic [TIME_W-1:0] c_deadline [NUM_TIMERS];
    logic [SLOT_W-1:0] c_slot     [NUM_TIMERS];
    logic              c_shift    [NUM_TIMERS];
    logic              c_due      [NUM_TIMERS];

    tq_cmd_t           cmd;
    logic              accept;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot_idx;
    logic              armed_now;
    logic              arm_ok;
    logic              out_free;
    logic              pop;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [DATA_W-1:0] ram_rdata;
    logic              ram_we;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign slot_ok   = 32'(req.slot) < NUM_TIMERS;
    assign slot_idx  = SLOT_W'(req.slot);
    assign armed_now = slot_ok && (status_reg[slot_idx] == ST_ARMED);
    assign out_free  = !out_valid_reg || rsp.ready;

    // A full queue cannot take another entry; with one entry per armed slot
    // this only guards the insert.
    assign arm_ok = accept && (req.mode == MODE_ARM) && slot_ok && !armed_now
                    && !c_valid[NUM_TIMERS-1];

    assign pop = (state_reg == S_CHECK) && c_due[0];

    assign cmd.insert = arm_ok;
    assign cmd.pop    = pop;
    assign cmd.key    = count_reg + req.timeout;
    assign cmd.now    = count_reg;

    assign ram_we = accept && (req.mode == MODE_SET) && slot_ok;

    // Lowest free slot; scanning downwards leaves the lowest match.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (status_reg[i] == ST_FREE)
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    generate
        for (genvar g = 0; g < NUM_TIMERS; g++)
        begin : g_cell
            logic              lv, ls, rv;
            logic [TIME_W-1:0] ld, rd;
            logic [SLOT_W-1:0] lsl, rsl;

            if (g == 0)
            begin : g_head
                assign lv  = 1'b1;
                assign ls  = 1'b0;
                assign ld  = '0;
                assign lsl = '0;
            end
            else
            begin : g_body
                assign lv  = c_valid[g-1];
                assign ls  = c_shift[g-1];
                assign ld  = c_deadline[g-1];
                assign lsl = c_slot[g-1];
            end

            if (g == NUM_TIMERS - 1)
            begin : g_tail
                assign rv  = 1'b0;
                assign rd  = '0;
                assign rsl = '0;
            end
            else
            begin : g_inner
                assign rv  = c_valid[g+1];
                assign rd  = c_deadline[g+1];
                assign rsl = c_slot[g+1];
            end

            tq_cell #(
                .SLOT_W (SLOT_W)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .cmd            (cmd),
                .new_slot       (slot_idx),
                .left_valid     (lv),
                .left_shift     (ls),
                .left_deadline  (ld),
                .left_slot      (lsl),
                .right_valid    (rv),
                .right_deadline (rd),
                .right_slot     (rsl),
                .valid          (c_valid[g]),
                .deadline       (c_deadline[g]),
                .slot           (c_slot[g]),
                .shift          (c_shift[g]),
                .due            (c_due[g])
            );
        end
    endgenerate

    // Data byte of each slot, read for the timer at the head of the queue.
    tq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_TIMERS)
    ) u_payload (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_idx),
        .wdata (req.data_byte),
        .re    (pop),
        .raddr (c_slot[0]),
        .rdata (ram_rdata)
    );

    // Slot status updates.
    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            status_next[i] = status_reg[i];
            if (accept && slot_ok && (slot_idx == SLOT_W'(i)))
            begin
                if ((req.mode == MODE_FREE) && (status_reg[i] != ST_ARMED))
                begin
                    status_next[i] = ST_FREE;
                end
                if (arm_ok)
                begin
                    status_next[i] = ST_ARMED;
                end
            end
            if ((state_reg == S_ALLOC) && out_free && free_found
                && (free_idx == SLOT_W'(i)))
            begin
                status_next[i] = ST_ALLOC;
            end
            if (pop && (c_slot[0] == SLOT_W'(i)))
            begin
                status_next[i] = ST_ALLOC;
            end
        end
    end

    // Sequencer and output register.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        fire_slot_next = fire_slot_reg;
        fire_last_next = fire_last_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_slot_next  = out_slot_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.mode == MODE_TICK)
                    begin
                        count_next = count_reg + 1'b1;
                        state_next = S_CHECK;
                    end
                    else if (req.mode == MODE_ALLOC)
                    begin
                        state_next = S_ALLOC;
                    end
                end
            end
            S_ALLOC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = free_found ? KIND_GRANT : KIND_FAIL;
                    out_slot_next  = free_found ? SLOT_FIELD_W'(free_idx) : '0;
                    out_data_next  = '0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (c_due[0])
                begin
                    // The entry behind the head decides whether this is the
                    // final expiry of the tick.
                    fire_slot_next = c_slot[0];
                    fire_last_next = !c_due[1];
                    state_next     = S_FIRE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FIRE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_EXPIRED;
                    out_slot_next  = SLOT_FIELD_W'(fire_slot_reg);
                    out_data_next  = ram_rdata;
                    out_last_next  = fire_last_reg;
                    state_next     = fire_last_reg ? S_IDLE : S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                status_reg[i] <= ST_FREE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                status_reg[i] <= status_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fire_slot_reg <= fire_slot_next;
        fire_last_reg <= fire_last_next;
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_kind = out_kind_reg;
    assign rsp.slot_index  = out_slot_reg;
    assign rsp.fired_data  = out_data_reg;
    assign rsp.last        = out_last_reg;

endmodule

>>> tb/sv/tb_sorted_timeout_timer_queue.sv
// Self-checking testbench for the sorted timeout timer queue: directed and random
// command streams, a predictor advanced once per accepted item, and checks on every result item.
// Depends on tq_pkg, tq_if (tq_req_if, tq_rsp_if) and the sorted_timeout_timer_queue RTL.
module tb_sorted_timeout_timer_queue;
    import tq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TIMERS  = DEFAULT_NUM_TIMERS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;
    localparam int REPORT_MAX  = 10;
    localparam int HOLD_CYCLES = 250;

    // Mode codes that the block does not use; they must pass without effect.
    localparam bit [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam bit [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    // One command item as it is offered on the request channel.
    typedef struct packed {
        bit [MODE_W-1:0]       mode;
        bit [SLOT_FIELD_W-1:0] slot;
        bit [TIME_W-1:0]       timeout;
        bit [DATA_W-1:0]       data;
    } timer_cmd_t;

    // One result item as it should leave on the result channel.
    typedef struct {
        kind_t                 kind;
        bit [SLOT_FIELD_W-1:0] slot;
        bit [DATA_W-1:0]       data;
        bit                    last;
    } timer_result_t;

    logic clk;
    logic rst_n;

    tq_req_if req_ch ();
    tq_rsp_if rsp_ch ();

    sorted_timeout_timer_queue #(
        .NUM_TIMERS (NUM_TIMERS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Timer model. It holds its own copy of the tick count, the slot pool
    // and the deadline-sorted queue, and is advanced once per accepted item.
    // ------------------------------------------------------------------
    bit [TIME_W-1:0]       model_count;
    slot_state_t           model_state    [NUM_TIMERS];
    bit [TIME_W-1:0]       model_deadline [NUM_TIMERS];
    bit [DATA_W-1:0]       model_payload  [NUM_TIMERS];
    bit [SLOT_FIELD_W-1:0] model_order    [$];

    // Results that the block owes us, oldest first.
    timer_result_t awaited_results [$];

    function automatic void advance_timer_model(timer_cmd_t cmd);
        bit [SLOT_FIELD_W-1:0] popped [$];
        timer_result_t         res;
        bit [TIME_W-1:0]       due;
        int                    pos;
        bit                    found;
        case (cmd.mode)
            MODE_TICK:
            begin
                // The count moves first; then every timer at the head whose
                // deadline is not after the new count leaves, in queue order.
                model_count = model_count + 32'd1;
                while (model_order.size() != 0
                       && model_deadline[model_order[0]] <= model_count)
                begin
                    popped.push_back(model_order.pop_front());
                end
                foreach (popped[i])
                begin
                    model_state[popped[i]] = ST_ALLOC;
                    res.kind = KIND_EXPIRED;
                    res.slot = popped[i];
                    res.data = model_payload[popped[i]];
                    res.last = (i == popped.size() - 1);
                    awaited_results.push_back(res);
                end
            end
            MODE_ALLOC:
            begin
                found    = 1'b0;
                res.slot = '0;
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (!found && model_state[i] == ST_FREE)
                    begin
                        found          = 1'b1;
                        model_state[i] = ST_ALLOC;
                        res.slot       = SLOT_FIELD_W'(i);
                    end
                end
                if (found)
                    res.kind = KIND_GRANT;
                else
                    res.kind = KIND_FAIL;
                res.data = '0;
                res.last = 1'b1;
                awaited_results.push_back(res);
            end
            MODE_FREE:
            begin
                if (cmd.slot < NUM_TIMERS && model_state[cmd.slot] != ST_ARMED)
                    model_state[cmd.slot] = ST_FREE;
            end
            MODE_SET:
            begin
                if (cmd.slot < NUM_TIMERS)
                    model_payload[cmd.slot] = cmd.data;
            end
            MODE_ARM:
            begin
                // An armed slot ignores a second arm. A new deadline goes
                // ahead of every queued timer with the same deadline.
                if (cmd.slot < NUM_TIMERS && model_state[cmd.slot] != ST_ARMED)
                begin
                    due                      = model_count + cmd.timeout;
                    model_deadline[cmd.slot] = due;
                    model_state[cmd.slot]    = ST_ARMED;
                    pos = 0;
                    while (pos < model_order.size()
                           && model_deadline[model_order[pos]] < due)
                    begin
                        pos++;
                    end
                    model_order.insert(pos, cmd.slot);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus store. The generator keeps just enough bookkeeping to stay
    // inside the contract: it never arms a slot whose data byte has not
    // been written, and it limits timers that would never expire.
    // ------------------------------------------------------------------
    timer_cmd_t pending_cmds [$];
    bit         payload_written [NUM_TIMERS];
    int         ticks_sent;
    int         stuck_arms;
    int         cmds_counted;

    task automatic queue_cmd(bit [MODE_W-1:0] mode, bit [SLOT_FIELD_W-1:0] slot,
                             bit [TIME_W-1:0] timeout, bit [DATA_W-1:0] data);
        timer_cmd_t cmd;
        cmd.mode    = mode;
        cmd.slot    = slot;
        cmd.timeout = timeout;
        cmd.data    = data;
        pending_cmds.push_back(cmd);
        if (mode == MODE_TICK)
            ticks_sent++;
        if (mode == MODE_SET)
            payload_written[slot] = 1'b1;
        if (mode <= MODE_ARM)
            cmds_counted++;
    endtask

    // Arms a slot, writing a data byte first if the slot has never had one.
    task automatic queue_arm(bit [SLOT_FIELD_W-1:0] slot, bit [TIME_W-1:0] timeout);
        if (!payload_written[slot])
            queue_cmd(MODE_SET, slot, $urandom, $urandom);
        queue_cmd(MODE_ARM, slot, timeout, $urandom);
    endtask

    // Mostly short timeouts so that timers expire within the run. Values just
    // below the wrap point give a deadline that wrapped past zero; they are
    // kept within the ticks already sent so that the deadline lies behind
    // the count. A few full-range values leave timers parked in the queue.
    function automatic bit [TIME_W-1:0] pick_timeout();
        int pick;
        int back;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(0, 8);
        if (pick < 85 || ticks_sent == 0)
            return $urandom_range(0, 100);
        if (pick < 95 || stuck_arms >= 4)
        begin
            back = $urandom_range(0, (ticks_sent > 16) ? 15 : ticks_sent - 1);
            return 32'hFFFF_FFFF - back;
        end
        stuck_arms++;
        return $urandom;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: bursts of random length separated by random gaps.
    // The model is advanced at the edge where an item is accepted.
    // ------------------------------------------------------------------
    timer_cmd_t offered;
    bit         offer_busy;
    int         gap_left;
    int         burst_left;
    int         items_taken;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offer_busy        = 1'b0;
            offered           = '0;
            gap_left          = 0;
            burst_left        = $urandom_range(1, 16);
            items_taken      <= 0;
            req_ch.valid     <= 1'b0;
            req_ch.mode      <= '0;
            req_ch.slot      <= '0;
            req_ch.timeout   <= '0;
            req_ch.data_byte <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                advance_timer_model(offered);
                offer_busy   = 1'b0;
                items_taken <= items_taken + 1;
            end
            if (!offer_busy && pending_cmds.size() != 0)
            begin
                if (gap_left != 0)
                    gap_left--;
                else
                begin
                    offered    = pending_cmds.pop_front();
                    offer_busy = 1'b1;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        // About four bursts in ten run straight on.
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            // Valid is assigned once per edge, so a held item never drops.
            req_ch.valid     <= offer_busy;
            req_ch.mode      <= offered.mode;
            req_ch.slot      <= offered.slot;
            req_ch.timeout   <= offered.timeout;
            req_ch.data_byte <= offered.data;
        end
    end

    // ------------------------------------------------------------------
    // Long hold-off on the result side. It is counted here in cycles and
    // starts twice, once early and once late, while the driver keeps
    // offering items so that the block backs up and stalls its input.
    // ------------------------------------------------------------------
    int hold_left;
    int holds_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if ((holds_done == 0 && items_taken >= 50)
                 || (holds_done == 1 && items_taken >= 200))
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Ready follows a rotating stall pattern that is
    // renewed whenever pattern_age wraps: sometimes all ones, sometimes half or a
    // quarter stalls. Each accepted result is checked against the oldest
    // awaited one.
    // ------------------------------------------------------------------
    bit [31:0]     stall_pattern;
    int            pattern_age;
    int            mismatches;
    timer_result_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_pattern = '1;
            pattern_age   = 0;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected result kind=%0d slot=%0d data=%02h last=%0b",
                                 $realtime, rsp_ch.result_kind, rsp_ch.slot_index,
                                 rsp_ch.fired_data, rsp_ch.last);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_ch.result_kind !== want.kind || rsp_ch.slot_index !== want.slot
                        || rsp_ch.fired_data !== want.data || rsp_ch.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"%0t: result mismatch: expected kind=%s slot=%0d ",
                                      "data=%02h last=%0b, got kind=%0d slot=%0d ",
                                      "data=%02h last=%0b"},
                                     $realtime, want.kind.name(), want.slot, want.data,
                                     want.last, rsp_ch.result_kind, rsp_ch.slot_index,
                                     rsp_ch.fired_data, rsp_ch.last);
                    end
                end
            end
            if (pattern_age == 63)
            begin
                pattern_age = 0;
                case ($urandom_range(0, 2))
                    0:       stall_pattern = '1;
                    1:       stall_pattern = $urandom;
                    default: stall_pattern = $urandom | $urandom;
                endcase
            end
            else
            begin
                pattern_age++;
                stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
            end
            rsp_ch.ready <= stall_pattern[0] && (hold_left == 0);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    int cycle_count;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    int pick;
    int chosen;

    initial
    begin
        rst_n            = 1'b0;
        model_count      = '0;
        mismatches       = 0;
        cycle_count      = 0;
        ticks_sent       = 0;
        stuck_arms       = 0;
        cmds_counted     = 0;
        foreach (model_state[i])
        begin
            model_state[i]     = ST_FREE;
            payload_written[i] = 1'b0;
        end

        // Directed opening. A tick with an empty queue gives nothing.
        queue_cmd(MODE_TICK, $urandom, $urandom, $urandom);
        queue_cmd(MODE_ALLOC, $urandom, $urandom, $urandom);
        queue_cmd(MODE_ALLOC, $urandom, $urandom, $urandom);
        queue_cmd(MODE_SET, 4'd0, $urandom, 8'h00);
        queue_cmd(MODE_SET, 4'd1, $urandom, 8'hFF);
        // Zero timeout, then an equal deadline that must overtake it.
        queue_cmd(MODE_ARM, 4'd0, 32'd0, $urandom);
        queue_cmd(MODE_ARM, 4'd1, 32'd0, $urandom);
        // Re-arm and free of an armed slot are both ignored.
        queue_cmd(MODE_ARM, 4'd0, 32'd5, $urandom);
        queue_cmd(MODE_FREE, 4'd0, $urandom, $urandom);
        queue_cmd(MODE_TICK, $urandom, $urandom, $urandom);
        // Arming a slot that was never allocated; deadline equal to the new count.
        queue_cmd(MODE_SET, 4'd15, $urandom, 8'hA5);
        queue_cmd(MODE_ARM, 4'd15, 32'd1, $urandom);
        queue_cmd(MODE_TICK, $urandom, $urandom, $urandom);
        queue_cmd(MODE_FREE, 4'd15, $urandom, $urandom);
        // Largest timeout: the deadline wraps behind the count and is due at once.
        queue_cmd(MODE_ARM, 4'd1, 32'hFFFF_FFFF, $urandom);
        queue_cmd(MODE_ARM, 4'd0, 32'd2, $urandom);
        queue_cmd(MODE_TICK, $urandom, $urandom, $urandom);
        queue_cmd(MODE_TICK, $urandom, $urandom, $urandom);
        // Spare mode codes do nothing.
        for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
            queue_cmd(MODE_W'(m), $urandom, $urandom, $urandom);
        queue_cmd(MODE_FREE, 4'd0, $urandom, $urandom);
        queue_cmd(MODE_FREE, 4'd1, $urandom, $urandom);
        queue_cmd(MODE_ALLOC, $urandom, $urandom, $urandom);

        // Fill the pool until allocation fails, then arm every slot with
        // a timeout of zero or one so that a single tick empties the queue.
        for (int s = 0; s < NUM_TIMERS; s++)
            queue_cmd(MODE_FREE, SLOT_FIELD_W'(s), $urandom, $urandom);
        repeat (NUM_TIMERS + 1)
            queue_cmd(MODE_ALLOC, $urandom, $urandom, $urandom);
        for (int s = 0; s < NUM_TIMERS; s++)
            queue_cmd(MODE_SET, SLOT_FIELD_W'(s), $urandom, $urandom);
        for (int s = 0; s < NUM_TIMERS; s++)
            queue_arm(SLOT_FIELD_W'(s), $urandom_range(0, 1));
        repeat (3)
            queue_cmd(MODE_TICK, $urandom, $urandom, $urandom);

        // Random part: allocate/set/arm/tick sequences with random content in
        // nearly half of the picks, the rest single commands and spare codes as noise.
        while (cmds_counted < 260)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                chosen = $urandom_range(0, NUM_TIMERS - 1);
                queue_cmd(MODE_ALLOC, $urandom, $urandom, $urandom);
                queue_cmd(MODE_SET, SLOT_FIELD_W'(chosen), $urandom, $urandom);
                queue_arm(SLOT_FIELD_W'(chosen), pick_timeout());
                repeat ($urandom_range(0, 3))
                    queue_cmd(MODE_TICK, $urandom, $urandom, $urandom);
            end
            else if (pick < 65)
                queue_cmd(MODE_TICK, $urandom, $urandom, $urandom);
            else if (pick < 73)
                queue_cmd(MODE_ALLOC, $urandom, $urandom, $urandom);
            else if (pick < 81)
                queue_cmd(MODE_FREE, $urandom, $urandom, $urandom);
            else if (pick < 87)
                queue_cmd(MODE_SET, $urandom, $urandom, $urandom);
            else if (pick < 96)
                queue_arm($urandom, pick_timeout());
            else
                queue_cmd(MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
                          $urandom, $urandom, $urandom);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Let every item go in, every awaited result come out, and then
        // watch a little longer for anything the block should not send.
        while (pending_cmds.size() != 0 || offer_busy)
            @(negedge clk);
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
